FILE: src/touch_pad_press_detector_defines.svh
// assertion macros for the touch pad press detector
// no dependencies; included by the top level only
`ifndef TOUCH_PAD_PRESS_DETECTOR_DEFINES_SVH
`define TOUCH_PAD_PRESS_DETECTOR_DEFINES_SVH

`ifndef SYNTHESIS

// condition implies consequence in the same cycle
`define TPD_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("tpd assertion failed");

// condition implies consequence in the next cycle
`define TPD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("tpd assertion failed");

`else

`define TPD_ASSERT_NOW(lbl, clk, rstn, ante, cons)
`define TPD_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

FILE: src/tpd_pkg.sv
// shared types, constants and tables of the touch pad press detector
// no dependencies; imported by every module of the block
package tpd_pkg;

    // field widths
    localparam int TIME_W    = 16;
    localparam int MODE_W    = 2;
    localparam int EVENT_W   = 2;
    localparam int CFG_W     = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CAL_SUM_W = 20;
    localparam int THR_W     = TIME_W + 1;

    // parameter defaults
    localparam int CAL_SAMPLES_DEF = 10;
    localparam int QUEUE_DEPTH_DEF = 4;

    // configuration register indexes and reset values
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_SIZE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_LOAD  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UPPER_MULT = 2'd3;

    localparam logic [CFG_W-1:0] SHORT_SIZE_RST = 4'd3;
    localparam logic [CFG_W-1:0] LONG_SIZE_RST  = 4'd6;
    localparam logic [CFG_W-1:0] HOLD_LOAD_RST  = 4'd3;
    localparam logic [CFG_W-1:0] UPPER_MULT_RST = 4'd10;

    // sample modes
    localparam logic [MODE_W-1:0] MODE_CAL    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_NORMAL = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CONT   = 2'd2;

    // result events
    localparam logic [EVENT_W-1:0] EV_NONE  = 2'd0;
    localparam logic [EVENT_W-1:0] EV_CAL   = 2'd1;
    localparam logic [EVENT_W-1:0] EV_GROUP = 2'd2;

    // samples above threshold needed for a group of n: floor(2n/3)
    localparam logic [CFG_W-1:0] NEED_TBL [16] = '{
        4'd0, 4'd0, 4'd1, 4'd2, 4'd2, 4'd3, 4'd4, 4'd4,
        4'd5, 4'd6, 4'd6, 4'd7, 4'd8, 4'd8, 4'd9, 4'd10
    };

    typedef struct packed {
        logic [TIME_W-1:0] charge_time;
        logic [MODE_W-1:0] mode;
    } t_in_item;

    typedef struct packed {
        logic [EVENT_W-1:0] event_res;
        logic               pressed;
        logic [TIME_W-1:0]  peak;
        logic [TIME_W-1:0]  baseline;
    } t_out_item;

    // classified word handed from front to back
    typedef struct packed {
        logic [EVENT_W-1:0] kind;
        logic               clr_hold;
        logic [TIME_W-1:0]  peak;
        logic [TIME_W-1:0]  base;
        logic [THR_W-1:0]   thr_lo;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef struct packed {
        logic busy;
    } t_front_stat;

    typedef enum logic [1:0] {
        FS_RUN,
        FS_DIV,
        FS_THR
    } t_front_state;

endpackage

FILE: src/tpd_front.sv
// front end: accepts samples, runs calibration and group accumulation
// depends on tpd_pkg; feeds classified words into tpd_queue
module tpd_front
    import tpd_pkg::*;
#(
    parameter int CAL_SAMPLES = CAL_SAMPLES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_in_item          i_in_data,
    input  logic [CFG_W-1:0]  i_short_size,
    input  logic [CFG_W-1:0]  i_long_size,
    input  t_q_stat           i_q_stat,
    output logic              o_push,
    output t_job              o_job,
    output t_front_stat       o_stat
);

    localparam int CNT_W     = $clog2(CAL_SAMPLES + 1);
    localparam int CAL_DIV   = CAL_SAMPLES - 4;
    localparam int CAL_SHIFT = CAL_SUM_W + $clog2(CAL_DIV);
    localparam int CAL_RECIP = ((1 << CAL_SHIFT) + CAL_DIV - 1) / CAL_DIV;
    localparam int PROD_W    = CAL_SUM_W + CAL_SHIFT + 1;
    localparam int DIV3_SHIFT = 20;
    localparam logic [18:0] DIV3_RECIP = 19'd349526;

    t_front_state r_state, n_state;

    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic [CAL_SUM_W-1:0] r_sum, n_sum;
    logic [TIME_W-1:0]    r_lo1, n_lo1, r_lo2, n_lo2;
    logic [TIME_W-1:0]    r_hi1, n_hi1, r_hi2, n_hi2;
    logic [CAL_SUM_W-1:0] r_mid, n_mid;
    logic [TIME_W-1:0]    r_base, n_base;
    logic [THR_W-1:0]     r_thr_ab, n_thr_ab;
    logic [THR_W-1:0]     r_thr_lo, n_thr_lo;
    logic [CFG_W-1:0]     r_gcnt, n_gcnt;
    logic [TIME_W-1:0]    r_gpeak, n_gpeak;
    logic [CFG_W-1:0]     r_gabove, n_gabove;
    logic                 r_glong, n_glong;

    logic                 accept;
    logic                 is_cal;
    logic [TIME_W-1:0]    t;

    // calibration path
    logic [TIME_W-1:0]    c_lo1, c_lo2, c_hi1, c_hi2;
    logic [CAL_SUM_W-1:0] c_sum;
    logic [TIME_W+1:0]    c_trim;
    logic [CAL_SUM_W-1:0] c_mid;
    logic [CNT_W-1:0]     c_cnt;

    // scan path
    logic                 g_start, g_long, g_clr, g_end;
    logic [CFG_W-1:0]     g_raw, g_n, g_cnt, g_above;
    logic [TIME_W-1:0]    g_peak, g_qpeak;

    // baseline divide and thresholds
    logic [PROD_W-1:0]    div_prod;
    logic [TIME_W+2:0]    ab_sum;
    logic [36:0]          lo_prod;

    assign t      = i_in_data.charge_time;
    assign is_cal = (i_in_data.mode == MODE_CAL);
    assign o_in_ready = (r_state == FS_RUN) && !i_q_stat.full;
    assign accept = i_in_valid && o_in_ready;
    assign o_stat.busy = (r_state != FS_RUN);

    // running two least and two greatest, wide sum, trimmed middle
    always_comb begin
        c_lo1 = r_lo1;
        c_lo2 = r_lo2;
        c_hi1 = r_hi1;
        c_hi2 = r_hi2;
        if (t < r_lo1) begin
            c_lo2 = r_lo1;
            c_lo1 = t;
        end else if (t < r_lo2) begin
            c_lo2 = t;
        end
        if (t > r_hi1) begin
            c_hi2 = r_hi1;
            c_hi1 = t;
        end else if (t > r_hi2) begin
            c_hi2 = t;
        end
    end

    assign c_sum  = r_sum + CAL_SUM_W'(t);
    assign c_trim = {2'b00, c_lo1} + {2'b00, c_lo2} + {2'b00, c_hi1} + {2'b00, c_hi2};
    assign c_mid  = (c_sum >= CAL_SUM_W'(c_trim)) ? (c_sum - CAL_SUM_W'(c_trim))
                                                  : '0;
    assign c_cnt  = r_cnt + CNT_W'(1);

    // group accumulation; the first sample latches the group mode
    assign g_start = (r_gcnt == '0);
    assign g_long  = g_start ? (i_in_data.mode >= MODE_CONT) : r_glong;
    assign g_clr   = g_start && (i_in_data.mode >= MODE_CONT);
    assign g_raw   = g_long ? i_long_size : i_short_size;
    assign g_n     = (g_raw == '0) ? CFG_W'(1) : g_raw;
    assign g_above = r_gabove + CFG_W'(THR_W'(t) > r_thr_ab);
    assign g_peak  = (t > r_gpeak) ? t : r_gpeak;
    assign g_cnt   = r_gcnt + CFG_W'(1);
    assign g_end   = (g_cnt >= g_n);
    assign g_qpeak = (g_above >= NEED_TBL[g_n]) ? g_peak : '0;

    // baseline = trimmed sum / (CAL_SAMPLES - 4) by reciprocal multiply
    assign div_prod = PROD_W'(r_mid) * PROD_W'(CAL_RECIP);

    // floor(5b/4) and floor(4b/3)
    assign ab_sum  = {1'b0, r_base, 2'b00} + {3'b000, r_base};
    assign lo_prod = 37'({r_base, 2'b00}) * 37'(DIV3_RECIP);

    // next state and word to the queue
    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_sum    = r_sum;
        n_lo1    = r_lo1;
        n_lo2    = r_lo2;
        n_hi1    = r_hi1;
        n_hi2    = r_hi2;
        n_mid    = r_mid;
        n_base   = r_base;
        n_thr_ab = r_thr_ab;
        n_thr_lo = r_thr_lo;
        n_gcnt   = r_gcnt;
        n_gpeak  = r_gpeak;
        n_gabove = r_gabove;
        n_glong  = r_glong;

        o_push          = 1'b0;
        o_job.kind      = EV_NONE;
        o_job.clr_hold  = 1'b0;
        o_job.peak      = '0;
        o_job.base      = r_base;
        o_job.thr_lo    = r_thr_lo;

        case (r_state)
            FS_RUN: begin
                if (accept) begin
                    if (is_cal) begin
                        n_sum = c_sum;
                        n_lo1 = c_lo1;
                        n_lo2 = c_lo2;
                        n_hi1 = c_hi1;
                        n_hi2 = c_hi2;
                        n_cnt = c_cnt;
                        if (c_cnt >= CNT_W'(CAL_SAMPLES)) begin
                            n_mid   = c_mid;
                            n_cnt   = '0;
                            n_sum   = '0;
                            n_lo1   = '1;
                            n_lo2   = '1;
                            n_hi1   = '0;
                            n_hi2   = '0;
                            n_state = FS_DIV;
                        end else begin
                            o_push = 1'b1;
                        end
                    end else begin
                        o_push         = 1'b1;
                        o_job.clr_hold = g_clr;
                        n_glong        = g_long;
                        n_gcnt         = g_cnt;
                        n_gpeak        = g_peak;
                        n_gabove       = g_above;
                        if (g_end) begin
                            n_gcnt     = '0;
                            n_gpeak    = '0;
                            n_gabove   = '0;
                            o_job.kind = EV_GROUP;
                            o_job.peak = g_qpeak;
                        end
                    end
                end
            end
            FS_DIV: begin
                n_base  = div_prod[CAL_SHIFT +: TIME_W];
                n_state = FS_THR;
            end
            FS_THR: begin
                n_thr_ab = ab_sum[TIME_W+2:2];
                n_thr_lo = lo_prod[DIV3_SHIFT +: THR_W];
                if (!i_q_stat.full) begin
                    o_push     = 1'b1;
                    o_job.kind = EV_CAL;
                    n_state    = FS_RUN;
                end
            end
            default: begin
                n_state = FS_RUN;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= FS_RUN;
            r_cnt    <= '0;
            r_sum    <= '0;
            r_lo1    <= '1;
            r_lo2    <= '1;
            r_hi1    <= '0;
            r_hi2    <= '0;
            r_base   <= '0;
            r_thr_ab <= '0;
            r_thr_lo <= '0;
            r_gcnt   <= '0;
            r_gpeak  <= '0;
            r_gabove <= '0;
            r_glong  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_sum    <= n_sum;
            r_lo1    <= n_lo1;
            r_lo2    <= n_lo2;
            r_hi1    <= n_hi1;
            r_hi2    <= n_hi2;
            r_base   <= n_base;
            r_thr_ab <= n_thr_ab;
            r_thr_lo <= n_thr_lo;
            r_gcnt   <= n_gcnt;
            r_gpeak  <= n_gpeak;
            r_gabove <= n_gabove;
            r_glong  <= n_glong;
        end
    end

    // trimmed sum, no reset needed
    always_ff @(posedge i_clk) begin
        r_mid <= n_mid;
    end

endmodule

FILE: src/tpd_queue.sv
// short fifo of classified words between front and back
// depends on tpd_pkg
module tpd_queue
    import tpd_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_job    i_job,
    input  logic    i_pop,
    output t_job    o_job,
    output t_q_stat o_stat
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_job              r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr, n_wr, r_rd, n_rd;
    logic [CNT_W-1:0]  r_cnt, n_cnt;

    assign o_stat.full  = (r_cnt == CNT_W'(DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign o_job        = r_mem[r_rd];

    // pointer and count update
    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + CNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule

FILE: src/tpd_back.sv
// back end: press window, hold-off counter and output register
// depends on tpd_pkg; drains tpd_queue
module tpd_back
    import tpd_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_job             i_job,
    input  t_q_stat          i_q_stat,
    output logic             o_pop,
    input  logic [CFG_W-1:0] i_hold_load,
    input  logic [CFG_W-1:0] i_upper_mult,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_out_item        o_out_data
);

    logic [CFG_W-1:0]       r_hold, n_hold;
    logic                   r_out_valid, n_out_valid;
    t_out_item              r_out, n_out;

    logic                   is_group;
    logic [CAL_SUM_W-1:0]   hi_lim;
    logic                   win;
    logic [CFG_W-1:0]       h0, h1, h2;

    assign o_pop       = !i_q_stat.empty && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // press window: floor(4b/3) < peak < upper * b
    assign is_group = (i_job.kind == EV_GROUP);
    assign hi_lim   = CAL_SUM_W'(i_upper_mult) * CAL_SUM_W'(i_job.base);
    assign win      = is_group && (THR_W'(i_job.peak) > i_job.thr_lo)
                      && (CAL_SUM_W'(i_job.peak) < hi_lim);

    // hold-off: cleared by a continuous group start, reloaded on a valid peak,
    // counted down at every group end
    assign h0 = i_job.clr_hold ? '0 : r_hold;
    assign h1 = win ? i_hold_load : h0;
    assign h2 = (h1 != '0) ? h1 - CFG_W'(1) : h1;

    always_comb begin
        n_hold      = r_hold;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (o_pop) begin
            n_hold              = is_group ? h2 : h0;
            n_out_valid         = 1'b1;
            n_out.event_res     = i_job.kind;
            n_out.pressed       = win && (h0 == '0);
            n_out.peak          = i_job.peak;
            n_out.baseline      = i_job.base;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_hold      <= n_hold;
            r_out_valid <= n_out_valid;
        end
    end

    // result word
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

endmodule

FILE: src/touch_pad_press_detector.sv
// top level of the touch pad press detector: config registers and wiring
// depends on tpd_pkg, tpd_front, tpd_queue, tpd_back and the defines header
//
//  channel  | valid       | ready       | word
//  ---------+-------------+-------------+----------------------------------
//  input    | i_in_valid  | o_in_ready  | i_in_data  (charge_time, mode)
//  result   | o_out_valid | i_out_ready | o_out_data (event_res .. baseline)
//  config   | i_cfg_valid | o_cfg_ready | i_cfg_index, i_cfg_data
//
// one sample per cycle while o_in_ready is high; an accepted sample's result is
// written into the queue, then into the output register, and is valid from there
// the sample that completes calibration holds the input off through FS_DIV,
// for the reciprocal multiply of the baseline divide, and FS_THR, for the
// threshold multiply, which also waits while the queue is full
// reset is synchronous and needs no clearing pass
// a stalled result side fills the queue, then drops o_in_ready
`include "touch_pad_press_detector_defines.svh"

module touch_pad_press_detector
    import tpd_pkg::*;
#(
    parameter int CAL_SAMPLES = CAL_SAMPLES_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_item             i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_item            o_out_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    logic [CFG_W-1:0] r_short_size, r_long_size, r_hold_load, r_upper_mult;

    logic        q_push, q_pop;
    t_job        q_in, q_out;
    t_q_stat     q_stat;
    t_front_stat f_stat;

    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_short_size <= SHORT_SIZE_RST;
            r_long_size  <= LONG_SIZE_RST;
            r_hold_load  <= HOLD_LOAD_RST;
            r_upper_mult <= UPPER_MULT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_SHORT_SIZE: r_short_size <= i_cfg_data;
                CFG_LONG_SIZE:  r_long_size  <= i_cfg_data;
                CFG_HOLD_LOAD:  r_hold_load  <= i_cfg_data;
                CFG_UPPER_MULT: r_upper_mult <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // front end
    tpd_front #(
        .CAL_SAMPLES (CAL_SAMPLES)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_data    (i_in_data),
        .i_short_size (r_short_size),
        .i_long_size  (r_long_size),
        .i_q_stat     (q_stat),
        .o_push       (q_push),
        .o_job        (q_in),
        .o_stat       (f_stat)
    );

    // decoupling queue
    tpd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (q_in),
        .i_pop   (q_pop),
        .o_job   (q_out),
        .o_stat  (q_stat)
    );

    // back end
    tpd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job        (q_out),
        .i_q_stat     (q_stat),
        .o_pop        (q_pop),
        .i_hold_load  (r_hold_load),
        .i_upper_mult (r_upper_mult),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_data   (o_out_data)
    );

    // checks
    `TPD_ASSERT_NOW(a_q_no_overflow, i_clk, i_rst_n, q_push, !q_stat.full)
    `TPD_ASSERT_NOW(a_q_no_underflow, i_clk, i_rst_n, q_pop, !q_stat.empty)
    `TPD_ASSERT_NOW(a_busy_stalls_input, i_clk, i_rst_n, f_stat.busy, !o_in_ready)
    `TPD_ASSERT_NOW(a_press_only_on_group, i_clk, i_rst_n,
                    o_out_valid && o_out_data.pressed, o_out_data.event_res == EV_GROUP)

endmodule

FILE: dv/touch_pad_press_detector_test.sv
`timescale 1ns / 100ps
// self-checking bench for the touch pad press detector: directed then random samples
// depends on tpd_pkg and the touch_pad_press_detector top level
module touch_pad_press_detector_test;
    import tpd_pkg::*;

    // spare mode code, decoded like a continuous scan sample
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
    localparam int LIMIT_CYCLES = 500000;
    localparam int DRAIN_CYCLES = 8;
    localparam int RAND_ITEMS   = 1250;
    localparam int PHASES       = 10;

    logic                 i_clk     = 1'b0;
    logic                 i_rst_n   = 1'b0;
    logic                 in_valid  = 1'b0;
    t_in_item             in_word   = '0;
    logic                 out_ready = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data  = '0;
    logic                 o_in_ready;
    logic                 o_out_valid;
    logic                 o_cfg_ready;
    t_out_item            o_out_data;

    touch_pad_press_detector i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // samples waiting to be sent, reports waiting to be seen
    t_in_item  pending_samples[$];
    t_out_item pending_reports[$];
    int        samples_queued = 0;
    int        reports_seen   = 0;
    int        mismatch_cnt   = 0;
    int        cycle_cnt      = 0;

    // predictor copy of the registers and detector state
    logic [CFG_W-1:0]     sz_short, sz_long, hold_load, upper_mult;
    logic [3:0]           cal_n;
    logic [CAL_SUM_W-1:0] cal_acc;
    logic [TIME_W-1:0]    lo1, lo2, hi1, hi2, base_est, grp_max;
    logic [3:0]           grp_n, grp_hits, hold_cnt;
    logic                 grp_long;

    // generator's view of the setting and of the baseline
    int gen_short = SHORT_SIZE_RST;
    int gen_long  = LONG_SIZE_RST;
    int gen_upper = UPPER_MULT_RST;
    int gen_base  = 0;

    // idling state of both sides
    int send_gap = 0, send_steady = 0;
    int recv_hold = 0, recv_steady = 0;
    bit flood_done = 1'b0;

    function automatic void clear_cal();
        cal_n   = '0;
        cal_acc = '0;
        lo1     = '1;
        lo2     = '1;
        hi1     = '0;
        hi2     = '0;
    endfunction

    // expected report for one sample, advancing the predictor state
    function automatic t_out_item predict_report(t_in_item w);
        t_out_item   r;
        logic [31:0] t, n, need, trim, mid;
        r = '0;
        t = 32'(w.charge_time);
        if (w.mode == MODE_CAL) begin
            cal_acc = cal_acc + CAL_SUM_W'(w.charge_time);
            if (w.charge_time < lo1) begin
                lo2 = lo1;
                lo1 = w.charge_time;
            end else if (w.charge_time < lo2) begin
                lo2 = w.charge_time;
            end
            if (w.charge_time > hi1) begin
                hi2 = hi1;
                hi1 = w.charge_time;
            end else if (w.charge_time > hi2) begin
                hi2 = w.charge_time;
            end
            cal_n = cal_n + 4'd1;
            if (32'(cal_n) >= CAL_SAMPLES_DEF) begin
                // trimmed mean of the calibration set
                trim = 32'(lo1) + 32'(lo2) + 32'(hi1) + 32'(hi2);
                mid = (32'(cal_acc) >= trim) ? 32'(cal_acc) - trim : 32'd0;
                base_est = TIME_W'(mid / (CAL_SAMPLES_DEF - 4));
                clear_cal();
                r.event_res = EV_CAL;
            end
        end else begin
            // first sample of a group latches its length
            if (grp_n == 0) begin
                grp_long = (w.mode != MODE_NORMAL);
                if (grp_long) hold_cnt = '0;
            end
            n = grp_long ? 32'(sz_long) : 32'(sz_short);
            if (n == 0) n = 1;
            if (t > (32'(base_est) * 5) / 4) grp_hits = grp_hits + 4'd1;
            if (w.charge_time > grp_max) grp_max = w.charge_time;
            grp_n = grp_n + 4'd1;
            if (32'(grp_n) >= n) begin
                need = (n * 2) / 3;
                if (32'(grp_hits) >= need) r.peak = grp_max;
                // press window is open at both ends
                if (32'(r.peak) > (32'(base_est) * 4) / 3 &&
                    32'(r.peak) < 32'(upper_mult) * 32'(base_est)) begin
                    if (hold_cnt == 0) r.pressed = 1'b1;
                    hold_cnt = hold_load;
                end
                if (hold_cnt != 0) hold_cnt = hold_cnt - 4'd1;
                grp_n    = '0;
                grp_max  = '0;
                grp_hits = '0;
                r.event_res = EV_GROUP;
            end
        end
        r.baseline = base_est;
        return r;
    endfunction

    task automatic check_field(string name, logic [TIME_W-1:0] want, logic [TIME_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatch_cnt++;
        end
    endtask

    // idle length: mostly none or short, a few long, now and then a steady run
    function automatic int pick_gap(inout int steady);
        int r;
        if (steady > 0) begin
            steady--;
            return 0;
        end
        r = $urandom_range(0, 199);
        if (r < 2) begin
            steady = $urandom_range(20, 80);
            return 0;
        end
        if (r < 110) return 0;
        if (r < 170) return $urandom_range(1, 3);
        if (r < 194) return $urandom_range(4, 12);
        return $urandom_range(20, 50);
    endfunction

    function automatic int clamp16(int v);
        return (v < 0) ? 0 : (v > 65535) ? 65535 : v;
    endfunction

    // calibration-like sample around a center, with an outlier now and then
    function automatic logic [TIME_W-1:0] near_value(int c);
        int spread;
        spread = c / 10 + 1;
        if ($urandom_range(0, 9) == 0) return TIME_W'($urandom_range(0, 65535));
        return TIME_W'(clamp16(c + int'($urandom_range(0, 2 * spread)) - spread));
    endfunction

    // scan sample placed around the thresholds of the current baseline
    function automatic logic [TIME_W-1:0] scan_value();
        int r, lo, hi, b, top;
        b   = gen_base;
        top = gen_upper * b;
        r   = $urandom_range(0, 99);
        if (r < 15) begin
            lo = 0;
            hi = b;
        end else if (r < 25) begin
            lo = b;
            hi = b * 4 / 3 + 1;
        end else if (r < 75) begin
            lo = b * 4 / 3;
            hi = (top > lo + 2) ? top : lo + 2;
        end else if (r < 85) begin
            lo = top - 2;
            hi = top + b;
        end else if (r < 95) begin
            // exact threshold edges
            case ($urandom_range(0, 5))
                0: lo = b * 5 / 4;
                1: lo = b * 5 / 4 + 1;
                2: lo = b * 4 / 3;
                3: lo = b * 4 / 3 + 1;
                4: lo = top - 1;
                default: lo = top;
            endcase
            hi = lo;
        end else begin
            lo = 0;
            hi = 65535;
        end
        lo = clamp16(lo);
        hi = clamp16(hi);
        if (hi < lo) hi = lo;
        return TIME_W'($urandom_range(hi, lo));
    endfunction

    task automatic add_sample(logic [TIME_W-1:0] t, logic [MODE_W-1:0] m);
        t_in_item w;
        w.charge_time = t;
        w.mode        = m;
        pending_samples.push_back(w);
        samples_queued++;
    endtask

    function automatic logic [MODE_W-1:0] scan_mode();
        int r;
        r = $urandom_range(0, 99);
        return (r < 55) ? MODE_NORMAL : (r < 90) ? MODE_CONT : MODE_SPARE;
    endfunction

    // random traffic: mostly whole calibration sets and scan groups
    task automatic make_traffic(int budget);
        int added, r, n, c, k;
        logic [MODE_W-1:0] m0;
        added = 0;
        while (added < budget) begin
            r = $urandom_range(0, 99);
            if (r < 12) begin
                r = $urandom_range(0, 99);
                c = (r < 80) ? $urandom_range(200, 3000) :
                    (r < 90) ? $urandom_range(0, 100) : $urandom_range(3000, 65535);
                for (k = 0; k < CAL_SAMPLES_DEF; k++) add_sample(near_value(c), MODE_CAL);
                gen_base = c;
                added += CAL_SAMPLES_DEF;
            end else if (r < 92) begin
                m0 = scan_mode();
                n  = (m0 == MODE_NORMAL) ? gen_short : gen_long;
                if (n == 0) n = 1;
                // broken group now and then, finished by the next one
                if ($urandom_range(0, 19) == 0) n = $urandom_range(1, n);
                add_sample(scan_value(), m0);
                for (k = 1; k < n; k++) begin
                    if ($urandom_range(0, 32) == 0) begin
                        add_sample(near_value(gen_base), MODE_CAL);
                        added++;
                    end
                    add_sample(scan_value(), ($urandom_range(0, 6) == 0) ? scan_mode() : m0);
                end
                added += n;
            end else begin
                add_sample(TIME_W'($urandom_range(0, 65535)), MODE_W'($urandom_range(0, 3)));
                added++;
            end
        end
    endtask

    // wait until every sent sample has its report, then let the pipe settle
    task automatic settle();
        while (reports_seen != samples_queued) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_put(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    // write all four registers back to back, block idle
    task automatic load_config(logic [CFG_W-1:0] s_sz, logic [CFG_W-1:0] l_sz,
                               logic [CFG_W-1:0] h_ld, logic [CFG_W-1:0] u_m);
        cfg_put(CFG_SHORT_SIZE, s_sz);
        cfg_put(CFG_LONG_SIZE, l_sz);
        cfg_put(CFG_HOLD_LOAD, h_ld);
        cfg_put(CFG_UPPER_MULT, u_m);
        cfg_valid <= 1'b0;
        gen_short = s_sz;
        gen_long  = l_sz;
        gen_upper = u_m;
    endtask

    // sample driver
    always @(posedge i_clk) begin
        logic busy;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            send_gap = 0;
        end else begin
            busy = in_valid && !o_in_ready;
            if (!busy) begin
                if (send_gap > 0) begin
                    send_gap--;
                    in_valid <= 1'b0;
                end else if (pending_samples.size() != 0) begin
                    in_word  <= pending_samples.pop_front();
                    in_valid <= 1'b1;
                    send_gap = pick_gap(send_steady);
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result receiver, with one long hold-off while samples keep coming
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else if (recv_hold > 0) begin
            recv_hold--;
            out_ready <= 1'b0;
        end else if (!flood_done && reports_seen > 300 && pending_samples.size() > 40) begin
            flood_done = 1'b1;
            recv_hold  = 250;
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
            recv_hold = pick_gap(recv_steady);
        end
    end

    // monitor: predicts on each accepted sample, checks each accepted word
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            sz_short   = SHORT_SIZE_RST;
            sz_long    = LONG_SIZE_RST;
            hold_load  = HOLD_LOAD_RST;
            upper_mult = UPPER_MULT_RST;
            clear_cal();
            base_est = '0;
            grp_n    = '0;
            grp_max  = '0;
            grp_hits = '0;
            grp_long = 1'b0;
            hold_cnt = '0;
        end else begin
            if (cfg_valid && o_cfg_ready) begin
                case (cfg_index)
                    CFG_SHORT_SIZE: sz_short   = cfg_data;
                    CFG_LONG_SIZE:  sz_long    = cfg_data;
                    CFG_HOLD_LOAD:  hold_load  = cfg_data;
                    CFG_UPPER_MULT: upper_mult = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && o_in_ready) pending_reports.push_back(predict_report(in_word));
            if (o_out_valid && out_ready) begin
                if (pending_reports.size() == 0) begin
                    $display("%0t: unexpected word, expected none, actual %h",
                             $time, o_out_data);
                    mismatch_cnt++;
                end else begin
                    want = pending_reports.pop_front();
                    check_field("event_res", want.event_res, o_out_data.event_res);
                    check_field("pressed", want.pressed, o_out_data.pressed);
                    check_field("peak", want.peak, o_out_data.peak);
                    check_field("baseline", want.baseline, o_out_data.baseline);
                end
                reports_seen++;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= LIMIT_CYCLES) begin
            $display("%0t: timeout", $time);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // reset, directed part, then random phases under changing settings
    initial begin
        int phase;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // zero baseline: group qualifies but the press window is empty
        add_sample(16'h0000, MODE_NORMAL);
        add_sample(16'hFFFF, MODE_NORMAL);
        add_sample(16'h0001, MODE_NORMAL);
        // calibration with both extremes twice, all trimmed away
        add_sample(16'h0000, MODE_CAL);
        add_sample(16'hFFFF, MODE_CAL);
        add_sample(16'd1000, MODE_CAL);
        add_sample(16'd1010, MODE_CAL);
        add_sample(16'd990, MODE_CAL);
        add_sample(16'd1005, MODE_CAL);
        add_sample(16'd995, MODE_CAL);
        add_sample(16'd1000, MODE_CAL);
        add_sample(16'hFFFF, MODE_CAL);
        add_sample(16'h0000, MODE_CAL);
        // press, then a second peak blocked by the hold-off
        add_sample(16'd1300, MODE_NORMAL);
        add_sample(16'd1400, MODE_NORMAL);
        add_sample(16'd1500, MODE_NORMAL);
        add_sample(16'd1400, MODE_NORMAL);
        add_sample(16'd1400, MODE_NORMAL);
        add_sample(16'd1400, MODE_NORMAL);
        // continuous group clears the hold-off; later modes and a calibration word ignored
        add_sample(16'd2000, MODE_CONT);
        add_sample(16'd2100, MODE_NORMAL);
        add_sample(16'd2200, MODE_SPARE);
        add_sample(16'd1000, MODE_CAL);
        add_sample(16'd2300, MODE_CONT);
        add_sample(16'd2400, MODE_CONT);
        add_sample(16'd2500, MODE_CONT);
        // peak equal to the upper bound is rejected
        add_sample(16'd10000, MODE_NORMAL);
        add_sample(16'd10000, MODE_NORMAL);
        add_sample(16'd10000, MODE_NORMAL);
        gen_base = 1000;
        settle();

        for (phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: load_config(4'd1, 4'd15, 4'd0, 4'd1);
                1: load_config(4'd15, 4'd1, 4'd15, 4'd15);
                2: load_config(4'd0, 4'd0, 4'd1, 4'd2);
                3: load_config(SHORT_SIZE_RST, LONG_SIZE_RST, HOLD_LOAD_RST, UPPER_MULT_RST);
                default: load_config(
                    ($urandom_range(0, 9) == 0) ? CFG_W'($urandom_range(0, 15)) :
                                                  CFG_W'($urandom_range(1, 6)),
                    ($urandom_range(0, 9) == 0) ? CFG_W'($urandom_range(0, 15)) :
                                                  CFG_W'($urandom_range(1, 8)),
                    CFG_W'($urandom_range(0, 15)),
                    ($urandom_range(0, 9) == 0) ? CFG_W'($urandom_range(0, 15)) :
                                                  CFG_W'($urandom_range(2, 12)));
            endcase
            make_traffic(RAND_ITEMS / PHASES);
            settle();
        end

        if (pending_reports.size() != 0) begin
            $display("%0t: %0d expected words never arrived", $time, pending_reports.size());
            mismatch_cnt++;
        end
        if (mismatch_cnt == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+src
src/tpd_pkg.sv
src/tpd_front.sv
src/tpd_queue.sv
src/tpd_back.sv
src/touch_pad_press_detector.sv
dv/touch_pad_press_detector_test.sv
